FILE: hdl/qslerp_pkg.sv
// Package for the quaternion slerp pipeline: widths, formats and the arctangent table.
// Used by quaternion_slerp and qslerp_cordic_stage; no dependencies of its own.
package qslerp_pkg;

	localparam int unsigned DATA_W = 16;
	localparam int unsigned THR_W = 15;
	localparam int unsigned QI = 30;
	localparam int unsigned ANG_W = 34;
	localparam int unsigned SQ_STEPS = 31;
	localparam int unsigned DIV_BITS = 30;
	localparam logic [ANG_W-1:0] CORDIC_GAIN = ANG_W'(64'd652032874);
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(16382);

	typedef logic signed [DATA_W-1:0] comp_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	typedef struct packed {
		comp_t x;
		comp_t y;
		comp_t z;
		comp_t w;
	} quat_t;

	typedef struct packed {
		quat_t q_start;
		quat_t q_end;
		comp_t fraction;
	} slerp_in_t;

	function automatic ang_t atan_entry(input logic [4:0] i);
		logic [31:0] v;
		begin
			case (i)
				5'd0: v = 32'd843314857;
				5'd1: v = 32'd497837829;
				5'd2: v = 32'd263043837;
				5'd3: v = 32'd133525159;
				5'd4: v = 32'd67021687;
				5'd5: v = 32'd33543516;
				5'd6: v = 32'd16775851;
				5'd7: v = 32'd8388437;
				5'd8: v = 32'd4194283;
				5'd9: v = 32'd2097149;
				5'd31: v = 32'd0;
				default: v = 32'd1 << (5'd30 - i);
			endcase
			return ANG_W'(v);
		end
	endfunction

endpackage

FILE: hdl/qslerp_if.sv
// Valid/ready stream interface carrying one slerp transfer payload.
// Depends on nothing; payload type is a parameter.
interface qslerp_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hdl/quaternion_slerp.sv
// Quaternion slerp, Q2.14 in and out; pipeline of dot product, square root, atan2,
// sine, division and blend. Throughput is one item a cycle while the output is
// not stalled; a stalled output freezes every stage.
// arst_n clears all valid bits and loads the threshold register with 16382.
// Depends on qslerp_pkg, qslerp_if and the stage modules.
module quaternion_slerp #(
	parameter int unsigned FRAC_BITS = 14,
	parameter int unsigned CORDIC_STEPS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [qslerp_pkg::THR_W-1:0] cfg_wdata,
	qslerp_if.sink   in_ch,
	qslerp_if.source out_ch
);
	localparam int unsigned SQ = qslerp_pkg::SQ_STEPS;
	localparam int unsigned DV = qslerp_pkg::DIV_BITS;
	// item record carried alongside the arithmetic
	typedef struct packed {
		qslerp_pkg::quat_t a;
		qslerp_pkg::quat_t b;
		logic [30:0] t30;
		logic        sel_a;
		logic        sel_b;
		logic        lin;
		logic        nonneg;
	} side_t;
	localparam int unsigned SW = $bits(side_t);
	localparam int unsigned LAT = 4 + SQ + CORDIC_STEPS + 1 + CORDIC_STEPS + DV + 2;

	logic en;
	logic [LAT-1:0] vld_q;
	logic [qslerp_pkg::THR_W-1:0] thr_q;

	assign en = !vld_q[LAT-1] || out_ch.ready;
	assign in_ch.ready = en;
	assign out_ch.valid = vld_q[LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			thr_q <= qslerp_pkg::THR_RESET;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (en) vld_q <= {vld_q[LAT-2:0], in_ch.valid};
		end
	end

	// stage 1: products, clamps on t
	side_t sd_s1;
	logic signed [32:0] pr_s1 [4];
	qslerp_pkg::slerp_in_t di;
	assign di = in_ch.data;
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s1.a <= di.q_start;
			sd_s1.b <= di.q_end;
			sd_s1.sel_a <= (di.fraction <= 0);
			sd_s1.sel_b <= FRAC_BITS <= 14 &&
				$signed({{16{di.fraction[15]}}, di.fraction}) >= $signed(32'(1) << FRAC_BITS);
			sd_s1.t30 <= 31'(({15'd0, di.fraction[15:0]}) << (30 - FRAC_BITS));
			sd_s1.lin <= 1'b0;
			sd_s1.nonneg <= 1'b0;
			pr_s1[0] <= 33'(di.q_start.x * di.q_end.x);
			pr_s1[1] <= 33'(di.q_start.y * di.q_end.y);
			pr_s1[2] <= 33'(di.q_start.z * di.q_end.z);
			pr_s1[3] <= 33'(di.q_start.w * di.q_end.w);
		end
	end

	// stage 2: dot sum, sign fix (the end quaternion is negated in the blend)
	side_t sd_s2;
	side_t sd2_d;
	logic signed [34:0] dot_s2;
	logic signed [34:0] dsum;
	assign dsum = 35'(pr_s1[0]) + 35'(pr_s1[1]) + 35'(pr_s1[2]) + 35'(pr_s1[3]);
	always_comb begin
		sd2_d = sd_s1;
		sd2_d.nonneg = !dsum[34];
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s2 <= sd2_d;
			dot_s2 <= dsum[34] ? -dsum : dsum;
		end
	end

	// stage 3: threshold test, cosine to Q30 with clamp
	side_t sd_s3;
	side_t sd3_d;
	logic [30:0] c_s3;
	logic signed [35:0] cfull;
	assign cfull = (2 * FRAC_BITS >= 30) ? 36'(dot_s2 >>> (2 * FRAC_BITS - 30 + 0))
		: 36'(dot_s2) <<< (30 - 2 * FRAC_BITS);
	always_comb begin
		sd3_d = sd_s2;
		sd3_d.lin = 49'(dot_s2) > (49'(thr_q) << FRAC_BITS);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s3 <= sd3_d;
			c_s3 <= (cfull > 36'sd1073741824) ? 31'd1073741824 : 31'(cfull);
		end
	end

	// stage 4: radicand 2^60 - c^2
	side_t sd_s4;
	logic [30:0] c_s4;
	logic [61:0] rad_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			sd_s4 <= sd_s3;
			c_s4 <= c_s3;
			rad_s4 <= 62'((64'd1 << 60) - 64'(c_s3) * 64'(c_s3));
		end
	end

	// square root, one bit a stage
	localparam int unsigned SQS = SW + 31;
	logic [61:0] sq_rem [SQ+1];
	logic [30:0] sq_root [SQ+1];
	logic [SQS-1:0] sq_side [SQ+1];
	assign sq_rem[0] = rad_s4;
	assign sq_root[0] = '0;
	assign sq_side[0] = {sd_s4, c_s4};
	for (genvar g = 0; g < SQ; g++) begin : g_sq
		qslerp_sqrt_stage #(.STEP(g), .SIDE_W(SQS)) u_sq (
			.clk(clk), .en(en),
			.rem_in(sq_rem[g]), .root_in(sq_root[g]), .side_in(sq_side[g]),
			.rem_out(sq_rem[g+1]), .root_out(sq_root[g+1]), .side_out(sq_side[g+1])
		);
	end

	side_t sd_r;
	logic [30:0] c_r, s_r;
	assign {sd_r, c_r} = sq_side[SQ];
	assign s_r = sq_root[SQ];

	// atan2 vectoring
	localparam int unsigned AS = SW + 31;
	qslerp_pkg::ang_t va_x [CORDIC_STEPS+1];
	qslerp_pkg::ang_t va_y [CORDIC_STEPS+1];
	qslerp_pkg::ang_t va_z [CORDIC_STEPS+1];
	logic [AS-1:0] va_side [CORDIC_STEPS+1];
	assign va_x[0] = qslerp_pkg::ANG_W'(c_r);
	assign va_y[0] = qslerp_pkg::ANG_W'(s_r);
	assign va_z[0] = '0;
	assign va_side[0] = {sd_r, s_r};
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_at
		qslerp_cordic_stage #(.SHIFT(g), .VECTORING(1'b1), .SIDE_W(AS)) u_at (
			.clk(clk), .en(en),
			.x_in(va_x[g]), .y_in(va_y[g]), .z_in(va_z[g]), .side_in(va_side[g]),
			.x_out(va_x[g+1]), .y_out(va_y[g+1]), .z_out(va_z[g+1]),
			.side_out(va_side[g+1])
		);
	end

	side_t sd_a;
	logic [30:0] s_a;
	assign {sd_a, s_a} = va_side[CORDIC_STEPS];

	// angle scale: (1-t)w and t w, both 31x34 products
	side_t sd_m;
	logic [30:0] s_m;
	qslerp_pkg::ang_t a0_m, a1_m;
	logic [63:0] om;
	assign om = 64'(va_z[CORDIC_STEPS]);
	always_ff @(posedge clk) begin
		if (en) begin
			sd_m <= sd_a;
			s_m <= s_a;
			a0_m <= qslerp_pkg::ANG_W'(((64'd1 << 30) - 64'(sd_a.t30)) * om >> 30);
			a1_m <= qslerp_pkg::ANG_W'((64'(sd_a.t30) * om) >> 30);
		end
	end

	// two sine rotations in parallel
	localparam int unsigned RS = SW + 31;
	qslerp_pkg::ang_t r0_x [CORDIC_STEPS+1];
	qslerp_pkg::ang_t r0_y [CORDIC_STEPS+1];
	qslerp_pkg::ang_t r0_z [CORDIC_STEPS+1];
	qslerp_pkg::ang_t r1_x [CORDIC_STEPS+1];
	qslerp_pkg::ang_t r1_y [CORDIC_STEPS+1];
	qslerp_pkg::ang_t r1_z [CORDIC_STEPS+1];
	logic [RS-1:0] r0_side [CORDIC_STEPS+1];
	logic [0:0] r1_side [CORDIC_STEPS+1];
	assign r0_x[0] = qslerp_pkg::CORDIC_GAIN;
	assign r0_y[0] = '0;
	assign r0_z[0] = a0_m;
	assign r1_x[0] = qslerp_pkg::CORDIC_GAIN;
	assign r1_y[0] = '0;
	assign r1_z[0] = a1_m;
	assign r0_side[0] = {sd_m, s_m};
	assign r1_side[0] = 1'b0;
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_sn
		qslerp_cordic_stage #(.SHIFT(g), .VECTORING(1'b0), .SIDE_W(RS)) u_s0 (
			.clk(clk), .en(en),
			.x_in(r0_x[g]), .y_in(r0_y[g]), .z_in(r0_z[g]), .side_in(r0_side[g]),
			.x_out(r0_x[g+1]), .y_out(r0_y[g+1]), .z_out(r0_z[g+1]),
			.side_out(r0_side[g+1])
		);
		qslerp_cordic_stage #(.SHIFT(g), .VECTORING(1'b0), .SIDE_W(1)) u_s1 (
			.clk(clk), .en(en),
			.x_in(r1_x[g]), .y_in(r1_y[g]), .z_in(r1_z[g]), .side_in(r1_side[g]),
			.x_out(r1_x[g+1]), .y_out(r1_y[g+1]), .z_out(r1_z[g+1]),
			.side_out(r1_side[g+1])
		);
	end

	side_t sd_c;
	logic [30:0] s_c;
	assign {sd_c, s_c} = r0_side[CORDIC_STEPS];

	// clamp sines to [0, 2^31-1]; quotient sv<<30/s over DV bits. sv < 2^31 so 61-bit
	// dividend; the top 31 quotient bits are zero whenever sv < s, else clamp.
	function automatic logic [30:0] pos31(input qslerp_pkg::ang_t v);
		if (v[qslerp_pkg::ANG_W-1]) return '0;
		else if (|v[qslerp_pkg::ANG_W-2:31]) return '1;
		else return v[30:0];
	endfunction
	logic [30:0] sv0, sv1;
	logic ovf0, ovf1;
	assign sv0 = pos31(r0_y[CORDIC_STEPS]);
	assign sv1 = pos31(r1_y[CORDIC_STEPS]);
	assign ovf0 = (sv0 > s_c) || (sv0 == s_c && s_c != 0);
	assign ovf1 = (sv1 > s_c) || (sv1 == s_c && s_c != 0);

	localparam int unsigned DSW = SW + 31 + 2;
	logic [31:0] d0_rem [DV+1], d0_dvd [DV+1], d1_rem [DV+1], d1_dvd [DV+1];
	logic [DSW-1:0] d0_side [DV+1];
	logic [0:0] d1_side [DV+1];
	// when sv < s the quotient's high part is zero and remainder starts at sv
	assign d0_rem[0] = {1'b0, sv0};
	assign d0_dvd[0] = '0;
	assign d1_rem[0] = {1'b0, sv1};
	assign d1_dvd[0] = '0;
	assign d0_side[0] = {sd_c, s_c, ovf0, ovf1};
	assign d1_side[0] = 1'b0;
	for (genvar g = 0; g < DV; g++) begin : g_dv
		qslerp_div_stage #(.SIDE_W(DSW)) u_d0 (
			.clk(clk), .en(en), .rem_in(d0_rem[g]), .dvd_in(d0_dvd[g]),
			.dvs_in(d0_side[g][DSW-SW-1:2]), .side_in(d0_side[g]),
			.rem_out(d0_rem[g+1]), .dvd_out(d0_dvd[g+1]), .side_out(d0_side[g+1])
		);
		qslerp_div_stage #(.SIDE_W(1)) u_d1 (
			.clk(clk), .en(en), .rem_in(d1_rem[g]), .dvd_in(d1_dvd[g]),
			.dvs_in(d0_side[g][DSW-SW-1:2]), .side_in(d1_side[g]),
			.rem_out(d1_rem[g+1]), .dvd_out(d1_dvd[g+1]), .side_out(d1_side[g+1])
		);
	end

	side_t sd_d;
	logic [30:0] s_d;
	logic o0_d, o1_d;
	assign {sd_d, s_d, o0_d, o1_d} = d0_side[DV];

	// weight select, then blend with four pairs of products (31x16 and 31x17)
	side_t sd_w;
	logic [30:0] k0_w, k1_w;
	always_ff @(posedge clk) begin
		if (en) begin
			sd_w <= sd_d;
			if (sd_d.lin || s_d == 0) begin
				k0_w <= 31'((32'd1 << 30) - 32'(sd_d.t30));
				k1_w <= sd_d.t30;
			end else begin
				k0_w <= o0_d ? 31'd1073741824 : d0_dvd[DV][30:0];
				k1_w <= o1_d ? 31'd1073741824 : d1_dvd[DV][30:0];
			end
		end
	end

	function automatic qslerp_pkg::comp_t blend(input logic [30:0] k0, input logic [30:0] k1,
		input qslerp_pkg::comp_t a, input qslerp_pkg::comp_t b, input logic neg);
		logic signed [16:0] bs;
		logic signed [48:0] acc;
		logic signed [48:0] r;
		begin
			// widen before negating so that -(-32768) survives
			bs = {b[15], b};
			if (neg) bs = -bs;
			acc = 49'($signed({1'b0, k0}) * a) + 49'($signed({1'b0, k1}) * bs)
				+ 49'sd536870912;
			r = acc >>> 30;
			if (r > 49'sd32767) return 16'sd32767;
			else if (r < -49'sd32768) return -16'sd32768;
			else return 16'(r);
		end
	endfunction

	qslerp_pkg::quat_t res_q;
	always_ff @(posedge clk) begin
		if (en) begin
			if (sd_w.sel_a) res_q <= sd_w.a;
			else if (sd_w.sel_b) begin
				// end quaternion without the sign fix
				res_q <= sd_w.b;
			end else begin
				res_q.x <= blend(k0_w, k1_w, sd_w.a.x, sd_w.b.x, !sd_w.nonneg);
				res_q.y <= blend(k0_w, k1_w, sd_w.a.y, sd_w.b.y, !sd_w.nonneg);
				res_q.z <= blend(k0_w, k1_w, sd_w.a.z, sd_w.b.z, !sd_w.nonneg);
				res_q.w <= blend(k0_w, k1_w, sd_w.a.w, sd_w.b.w, !sd_w.nonneg);
			end
		end
	end
	assign out_ch.data = res_q;

endmodule

FILE: hdl/qslerp_cordic_stage.sv
// One CORDIC micro-rotation with its pipeline register (vectoring or rotation mode).
// Depends on qslerp_pkg.
module qslerp_cordic_stage #(
	parameter int unsigned SHIFT = 0,
	parameter bit VECTORING = 1'b0,
	parameter int unsigned SIDE_W = 1
) (
	input  logic                   clk,
	input  logic                   en,
	input  qslerp_pkg::ang_t       x_in,
	input  qslerp_pkg::ang_t       y_in,
	input  qslerp_pkg::ang_t       z_in,
	input  logic [SIDE_W-1:0]      side_in,
	output qslerp_pkg::ang_t       x_out,
	output qslerp_pkg::ang_t       y_out,
	output qslerp_pkg::ang_t       z_out,
	output logic [SIDE_W-1:0]      side_out
);
	qslerp_pkg::ang_t xs, ys, at;
	logic pos;

	assign xs  = x_in >>> (SHIFT % 32);
	assign ys  = y_in >>> (SHIFT % 32);
	assign at  = qslerp_pkg::atan_entry(5'(SHIFT % 32));
	assign pos = VECTORING ? !y_in[$bits(y_in)-1] : !z_in[$bits(z_in)-1];

	always_ff @(posedge clk) begin
		if (en) begin
			if (VECTORING) begin
				x_out <= pos ? x_in + ys : x_in - ys;
				y_out <= pos ? y_in - xs : y_in + xs;
				z_out <= pos ? z_in + at : z_in - at;
			end else begin
				x_out <= pos ? x_in - ys : x_in + ys;
				y_out <= pos ? y_in + xs : y_in - xs;
				z_out <= pos ? z_in - at : z_in + at;
			end
			side_out <= side_in;
		end
	end
endmodule

FILE: hdl/qslerp_sqrt_stage.sv
// One restoring square-root step (one result bit) with its pipeline register.
// Depends on nothing.
module qslerp_sqrt_stage #(
	parameter int unsigned STEP = 0,
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [61:0]       rem_in,
	input  logic [30:0]       root_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [61:0]       rem_out,
	output logic [30:0]       root_out,
	output logic [SIDE_W-1:0] side_out
);
	localparam int unsigned POS = 30 - STEP;
	logic [63:0] trial;

	// trial = (2*root + 2^pos) << pos, root holds the upper bits found so far
	assign trial = ({33'd0, root_in} << (POS + 1)) | (64'd1 << (2 * POS));

	always_ff @(posedge clk) begin
		if (en) begin
			if ({2'b00, rem_in} >= trial) begin
				rem_out  <= rem_in - trial[61:0];
				root_out <= root_in | (31'd1 << POS);
			end else begin
				rem_out  <= rem_in;
				root_out <= root_in;
			end
			side_out <= side_in;
		end
	end
endmodule

FILE: hdl/qslerp_div_stage.sv
// One restoring division step (one quotient bit) with its pipeline register.
// Depends on nothing.
module qslerp_div_stage #(
	parameter int unsigned SIDE_W = 1
) (
	input  logic              clk,
	input  logic              en,
	input  logic [31:0]       rem_in,
	input  logic [31:0]       dvd_in,
	input  logic [30:0]       dvs_in,
	input  logic [SIDE_W-1:0] side_in,
	output logic [31:0]       rem_out,
	output logic [31:0]       dvd_out,
	output logic [SIDE_W-1:0] side_out
);
	logic [32:0] sh;
	assign sh = {rem_in, dvd_in[31]};

	always_ff @(posedge clk) begin
		if (en) begin
			if (sh >= {2'b00, dvs_in}) begin
				rem_out <= 32'(sh - {2'b00, dvs_in});
				dvd_out <= {dvd_in[30:0], 1'b1};
			end else begin
				rem_out <= sh[31:0];
				dvd_out <= {dvd_in[30:0], 1'b0};
			end
			side_out <= side_in;
		end
	end
endmodule

FILE: tb/slerp_checker.sv
// Scoreboard for the quaternion slerp block: predicts each interpolation and compares outputs.
// Depends on qslerp_pkg; connects to the channel signals and the threshold write port.
module slerp_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [qslerp_pkg::THR_W-1:0] cfg_wdata,
	input  logic       in_valid,
	input  logic       in_ready,
	input  qslerp_pkg::slerp_in_t in_data,
	input  logic       out_valid,
	input  logic       out_ready,
	input  qslerp_pkg::quat_t out_data,
	output int         outstanding,
	output int         fails
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint ONE30 = 64'sd1 << 30;
	localparam longint ROT_GAIN = 64'sd652032874;
	localparam longint ANGLES[16] = '{
		843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
		16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
		131072, 65536, 32768};

	logic [qslerp_pkg::THR_W-1:0] threshold;
	qslerp_pkg::quat_t expected_q[$];

	function automatic longint unsigned root_floor(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		for (int i = 0; i < 32; i++) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint angle_of(longint x, longint y);
		longint z, nx, ny;
		z = 0;
		for (int i = 0; i < 16; i++) begin
			if (y >= 0) begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				z += ANGLES[i];
			end else begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				z -= ANGLES[i];
			end
			x = nx;
			y = ny;
		end
		return z;
	endfunction

	function automatic longint sine_of(longint a);
		longint x, y, nx, ny;
		x = ROT_GAIN;
		y = 0;
		for (int i = 0; i < 16; i++) begin
			if (a >= 0) begin
				nx = x - (y >>> i);
				ny = y + (x >>> i);
				a -= ANGLES[i];
			end else begin
				nx = x + (y >>> i);
				ny = y - (x >>> i);
				a += ANGLES[i];
			end
			x = nx;
			y = ny;
		end
		return y;
	endfunction

	function automatic longint blend_weight(longint a, longint sine);
		longint sv;
		longint unsigned k;
		sv = sine_of(a);
		if (sv < 0)
			sv = 0;
		k = (longint'(sv) << 30) / longint'(unsigned'(sine));
		if (k > longint'(unsigned'(ONE30)))
			k = ONE30;
		return longint'(k);
	endfunction

	function automatic qslerp_pkg::quat_t interpolate(qslerp_pkg::slerp_in_t it,
		logic [qslerp_pkg::THR_W-1:0] thr);
		longint a[4], b[4], t, dot, k0, k1, t30, c, s, omega, acc, r;
		longint unsigned prod;
		qslerp_pkg::quat_t q;
		a = '{longint'(it.q_start.x), longint'(it.q_start.y),
			longint'(it.q_start.z), longint'(it.q_start.w)};
		b = '{longint'(it.q_end.x), longint'(it.q_end.y),
			longint'(it.q_end.z), longint'(it.q_end.w)};
		t = longint'(it.fraction);
		if (t <= 0)
			return it.q_start;
		if (t >= 16384)
			return it.q_end;
		dot = 0;
		for (int i = 0; i < 4; i++)
			dot += a[i] * b[i];
		if (dot < 0) begin
			for (int i = 0; i < 4; i++)
				b[i] = -b[i];
			dot = -dot;
		end
		t30 = t << 16;
		k0 = ONE30 - t30;
		k1 = t30;
		if (dot <= (longint'(thr) << 14)) begin
			c = dot << 2;
			if (c > ONE30)
				c = ONE30;
			prod = longint'(unsigned'(c)) * longint'(unsigned'(c));
			s = longint'(root_floor((64'd1 << 60) - prod));
			if (s > 0) begin
				omega = angle_of(c, s);
				k0 = blend_weight(longint'((longint'(unsigned'(ONE30 - t30))
					* longint'(unsigned'(omega))) >> 30), s);
				k1 = blend_weight(longint'((longint'(unsigned'(t30))
					* longint'(unsigned'(omega))) >> 30), s);
			end
		end
		for (int i = 0; i < 4; i++) begin
			acc = k0 * a[i] + k1 * b[i];
			r = (acc + (64'sd1 << 29)) >>> 30;
			if (r > 32767)
				r = 32767;
			if (r < -32768)
				r = -32768;
			case (i)
				0: q.x = qslerp_pkg::comp_t'(r);
				1: q.y = qslerp_pkg::comp_t'(r);
				2: q.z = qslerp_pkg::comp_t'(r);
				default: q.w = qslerp_pkg::comp_t'(r);
			endcase
		end
		return q;
	endfunction

	task automatic report(string what, int got, int want);
		$display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
		fails++;
	endtask

	assign outstanding = expected_q.size();

	initial fails = 0;

	always @(posedge clk or negedge arst_n) begin
		qslerp_pkg::quat_t want;
		if (!arst_n) begin
			threshold <= qslerp_pkg::THR_RESET;
		end else begin
			if (cfg_we)
				threshold <= cfg_wdata;
			if (in_valid && in_ready)
				expected_q.push_back(interpolate(in_data, threshold));
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					report("unexpected transfer", out_data.x, 0);
				end else begin
					want = expected_q.pop_front();
					if (out_data.x !== want.x) report("out_x", out_data.x, want.x);
					if (out_data.y !== want.y) report("out_y", out_data.y, want.y);
					if (out_data.z !== want.z) report("out_z", out_data.z, want.z);
					if (out_data.w !== want.w) report("out_w", out_data.w, want.w);
				end
			end
		end
	end
endmodule

FILE: tb/tb_quaternion_slerp.sv
// Top of the slerp testbench: clock, reset, stimulus, threshold phases and the verdict.
// Depends on qslerp_pkg, qslerp_if, quaternion_slerp and slerp_checker.
module tb_quaternion_slerp;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [qslerp_pkg::THR_W-1:0] cfg_wdata = '0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	logic hold_go = 0;
	logic hold_used = 0;
	int hold_left = 0;
	int outstanding, fails, quiet;

	qslerp_if #(.T(qslerp_pkg::slerp_in_t)) in_ch();
	qslerp_if #(.T(qslerp_pkg::quat_t)) out_ch();

	quaternion_slerp dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch.sink), .out_ch(out_ch.source)
	);

	slerp_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
		.outstanding(outstanding), .fails(fails)
	);

	always #1 clk = ~clk;

	initial begin
		in_ch.valid = 0;
		in_ch.data = '0;
		out_ch.ready = 0;
	end

	// receiver: random stalls, plus one long hold-off so the pipe backs up
	always @(posedge clk) begin
		if (hold_go && !hold_used) begin
			hold_used <= 1;
			hold_left <= 400;
			out_ch.ready <= 0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= STALL_LIMIT) begin
			$display("tb_quaternion_slerp: FAIL");
			$finish;
		end
	end

	task automatic send(qslerp_pkg::slerp_in_t item);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data <= item;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic set_threshold(logic [qslerp_pkg::THR_W-1:0] v);
		in_ch.valid <= 0;
		@(posedge clk);
		wait (outstanding == 0);
		// let the pipe drain fully before touching the register
		repeat (200) @(posedge clk);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 0;
	endtask

	function automatic qslerp_pkg::comp_t unit_comp();
		return qslerp_pkg::comp_t'($urandom_range(0, 32768) - 16384);
	endfunction

	function automatic qslerp_pkg::slerp_in_t random_item();
		qslerp_pkg::slerp_in_t it;
		int mode;
		mode = $urandom_range(0, 99);
		it.q_start = '{unit_comp(), unit_comp(), unit_comp(), unit_comp()};
		if (mode < 15) begin
			it.q_start = qslerp_pkg::quat_t'({$urandom, $urandom});
			it.q_end = qslerp_pkg::quat_t'({$urandom, $urandom});
		end else if (mode < 45) begin
			// nearly parallel, sometimes flipped, to reach the linear path
			it.q_end.x = it.q_start.x + qslerp_pkg::comp_t'($urandom_range(0, 40) - 20);
			it.q_end.y = it.q_start.y + qslerp_pkg::comp_t'($urandom_range(0, 40) - 20);
			it.q_end.z = it.q_start.z + qslerp_pkg::comp_t'($urandom_range(0, 40) - 20);
			it.q_end.w = it.q_start.w + qslerp_pkg::comp_t'($urandom_range(0, 40) - 20);
			if (mode < 30)
				it.q_end = '{-it.q_end.x, -it.q_end.y, -it.q_end.z, -it.q_end.w};
		end else begin
			it.q_end = '{unit_comp(), unit_comp(), unit_comp(), unit_comp()};
		end
		if ($urandom_range(0, 99) < 85)
			it.fraction = qslerp_pkg::comp_t'($urandom_range(1, 16383));
		else
			it.fraction = qslerp_pkg::comp_t'($urandom);
		return it;
	endfunction

	function automatic qslerp_pkg::slerp_in_t mk(qslerp_pkg::quat_t a, qslerp_pkg::quat_t b,
		int t);
		qslerp_pkg::slerp_in_t it;
		it.q_start = a;
		it.q_end = b;
		it.fraction = qslerp_pkg::comp_t'(t);
		return it;
	endfunction

	initial begin
		qslerp_pkg::quat_t ident, qx, qmax, qmin, half;
		logic [qslerp_pkg::THR_W-1:0] thr_set[4];
		int sidle[4], ridle[4];
		ident = '{0, 0, 0, 16384};
		qx = '{16384, 0, 0, 0};
		qmax = '{32767, 32767, 32767, 32767};
		qmin = '{-32768, -32768, -32768, -32768};
		half = '{11585, 0, 0, 11585};
		thr_set = '{qslerp_pkg::THR_RESET, 0, 16384,
			qslerp_pkg::THR_W'($urandom_range(0, 16384))};
		sidle = '{0, 62, 0, 15};
		ridle = '{0, 0, 62, 15};
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: fraction limits, opposite signs, saturation, non-unit inputs
		send(mk(qx, ident, 0));
		send(mk(qx, ident, -32768));
		send(mk(qx, ident, 16384));
		send(mk(qx, ident, 32767));
		send(mk(qx, ident, 1));
		send(mk(qx, ident, 16383));
		send(mk(qx, ident, 8192));
		send(mk(ident, half, 8192));
		send(mk(ident, '{0, 0, 0, -16384}, 4096));
		send(mk(ident, ident, 8192));
		send(mk(half, '{-11585, 0, 0, -11600}, 8192));
		send(mk(qmax, qmax, 8192));
		send(mk(qmin, qmin, 8192));
		send(mk(qmax, qmin, 5000));
		send(mk(qmin, qmax, 32767));
		send(mk(qmax, qmin, -1));
		send(mk('{0, 0, 0, 0}, '{0, 0, 0, 0}, 8192));
		send(mk(qx, '{-32768, 0, 0, 0}, 12000));
		send(mk(qmax, '{32767, -32768, 32767, -32768}, 3000));
		send(mk(ident, '{0, 0, 16384, 1}, 16000));

		for (int p = 0; p < 4; p++) begin
			set_threshold(thr_set[p]);
			send_idle_pct = sidle[p];
			recv_idle_pct = ridle[p];
			if (p == 0)
				hold_go <= 1;
			for (int n = 0; n < 345; n++)
				send(random_item());
		end
		set_threshold(qslerp_pkg::THR_W'(16383));
		for (int n = 0; n < 20; n++)
			send(random_item());
		in_ch.valid <= 0;

		wait (outstanding == 0);
		repeat (200) @(posedge clk);
		if (fails == 0 && outstanding == 0)
			$display("tb_quaternion_slerp: PASS");
		else
			$display("tb_quaternion_slerp: FAIL");
		$finish;
	end
endmodule

FILE: filelist.f
hdl/qslerp_pkg.sv
hdl/qslerp_if.sv
hdl/qslerp_cordic_stage.sv
hdl/qslerp_sqrt_stage.sv
hdl/qslerp_div_stage.sv
hdl/quaternion_slerp.sv
tb/slerp_checker.sv
tb/tb_quaternion_slerp.sv
